// File: hdl/eas_pkg.sv
`default_nettype none

package eas_pkg;

  localparam int unsigned ModeW      = 3;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned NumCoords  = 3;
  localparam int unsigned SampleW    = 32;
  localparam int unsigned SampleFrac = 30;

  // pipeline stages, in order
  localparam int unsigned NumStages = 6;
  localparam int unsigned StPrep    = 0;
  localparam int unsigned StSquare  = 1;
  localparam int unsigned StMix     = 2;
  localparam int unsigned StEase    = 3;
  localparam int unsigned StScale   = 4;
  localparam int unsigned StOut     = 5;

  typedef logic [NumStages-1:0] stage_en_t;
  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [ModeW-1:0] {
    MODE_LINEAR  = 3'd0,
    MODE_IN      = 3'd1,
    MODE_OUT     = 3'd2,
    MODE_IN_OUT  = 3'd3,
    MODE_BOUNCE  = 3'd4,
    MODE_ELASTIC = 3'd5
  } mode_e;

endpackage

`default_nettype wire

// File: hdl/easing_interpolator.sv
// Easing interpolator: eased progress and three interpolated coordinates.
// Throughput: one transfer per cycle unless m_axis_tready stalls the output;
// each stage carries one multiplier or one wide add and compare, the elastic
// table is read in a registered stage.
// Reset clears the stage valid bits only; no other state and no clearing pass.
`default_nettype none

module easing_interpolator import eas_pkg::*; #(
  parameter int unsigned FracBits   = 16,
  parameter int unsigned TableDepth = 256,
  localparam int unsigned InFieldW  = ModeW + FracBits + 1 + 2 * NumCoords * CoordW,
  localparam int unsigned InW       = ((InFieldW + 7) / 8) * 8,
  localparam int unsigned OutFieldW = FracBits + 2 + NumCoords * CoordW,
  localparam int unsigned OutW      = ((OutFieldW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // mode, progress, start_x, start_y, start_z, end_x, end_y, end_z
  input  wire logic [InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // eased, pos_x, pos_y, pos_z
  output logic [OutW-1:0]      m_axis_tdata
);

  localparam int unsigned ProgLo  = ModeW;
  localparam int unsigned StartLo = ModeW + FracBits + 1;
  localparam int unsigned EndLo   = StartLo + NumCoords * CoordW;

  // ---- stage valids and enables ----
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages-1:0] vld_in;
  stage_en_t            en;

  always_comb begin
    en[StOut] = !vld_q[StOut] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign vld_in = {vld_q[NumStages-2:0], s_axis_tvalid};
  assign vld_d  = (en & vld_in) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[StPrep];
  assign m_axis_tvalid = vld_q[StOut];

  // ---- unpack ----
  logic [ModeW-1:0]  mode;
  logic [FracBits:0] progress;
  coord_t            start_c [NumCoords];
  coord_t            end_c   [NumCoords];

  assign mode     = s_axis_tdata[ModeW-1:0];
  assign progress = s_axis_tdata[ProgLo +: FracBits + 1];

  for (genvar c = 0; c < NumCoords; c++) begin : g_unpack
    assign start_c[c] = s_axis_tdata[StartLo + c * CoordW +: CoordW];
    assign end_c[c]   = s_axis_tdata[EndLo + c * CoordW +: CoordW];
  end

  // ---- datapath ----
  logic signed [FracBits+1:0] eased_mid;
  logic signed [FracBits+1:0] eased_out;
  coord_t                     pos [NumCoords];

  eas_curve #(
    .FracBits   (FracBits),
    .TableDepth (TableDepth)
  ) u_curve (
    .clk_i      (clk_i),
    .en_i       (en),
    .mode_i     (mode),
    .progress_i (progress),
    .eased_o    (eased_mid)
  );

  eas_lerp #(
    .FracBits (FracBits)
  ) u_lerp (
    .clk_i   (clk_i),
    .en_i    (en),
    .start_i (start_c),
    .end_i   (end_c),
    .eased_i (eased_mid),
    .eased_o (eased_out),
    .pos_o   (pos)
  );

  assign m_axis_tdata = OutW'({pos[2], pos[1], pos[0], eased_out});

endmodule

`default_nettype wire

// File: hdl/eas_rom.sv
`default_nettype none

module eas_rom import eas_pkg::*; #(
  parameter int unsigned TableDepth = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic [$clog2(TableDepth)-1:0]    idx_i,
  output logic signed [SampleW-1:0]             lo_o,
  output logic signed [SampleW-1:0]             hi_o
);

  localparam int unsigned IdxW      = $clog2(TableDepth);
  localparam int unsigned EvenDepth = (TableDepth + 1) / 2;
  localparam int unsigned OddDepth  = TableDepth / 2;
  localparam int unsigned EvenW     = $clog2(EvenDepth);
  localparam int unsigned OddW      = $clog2(OddDepth);

  localparam longint unsigned TblD1    = 64'(TableDepth - 1);
  localparam longint unsigned TblMod   = 12 * TblD1;
  localparam longint unsigned Q30      = 64'd1 << 30;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;
  localparam longint unsigned Ln2Q30   = 64'd744261118;

  // sample i of -(2^(10(x-1)) * sin(2pi(x-1.075)/0.3)), Q2.30, built at elaboration
  function automatic logic signed [SampleW-1:0] elastic_sample(input longint unsigned i);
    longint unsigned ph;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned q;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned k;
    longint unsigned fr;
    longint unsigned y;
    longint unsigned ex;
    longint          s;
    longint          prod;
    ph   = (((40 * i + 5 * TblD1) % TblMod) << 32) / TblMod;
    quad = (ph >> 30) & 64'd3;
    r    = ph & (Q30 - 1);
    q    = quad[0] ? (Q30 - r) : r;
    x    = (q * TwoPiQ30) >> 32;
    x2   = (x * x) >> 30;
    term = Q30;
    term = Q30 - ((x2 * term) >> 30) / 110;
    term = Q30 - ((x2 * term) >> 30) / 72;
    term = Q30 - ((x2 * term) >> 30) / 42;
    term = Q30 - ((x2 * term) >> 30) / 20;
    term = Q30 - ((x2 * term) >> 30) / 6;
    term = (x * term) >> 30;
    s    = quad[1] ? -longint'(term) : longint'(term);
    k    = (10 * i) / TblD1;
    fr   = (((10 * i) % TblD1) << 30) / TblD1;
    y    = (fr * Ln2Q30) >> 30;
    term = Q30;
    term = Q30 + ((y * term) >> 30) / 10;
    term = Q30 + ((y * term) >> 30) / 9;
    term = Q30 + ((y * term) >> 30) / 8;
    term = Q30 + ((y * term) >> 30) / 7;
    term = Q30 + ((y * term) >> 30) / 6;
    term = Q30 + ((y * term) >> 30) / 5;
    term = Q30 + ((y * term) >> 30) / 4;
    term = Q30 + ((y * term) >> 30) / 3;
    term = Q30 + ((y * term) >> 30) / 2;
    term = Q30 + ((y * term) >> 30) / 1;
    ex   = term >> (10 - k);
    prod = longint'(ex) * s;
    return SampleW'(-((prod + (64'sd1 <<< 29)) >>> 30));
  endfunction

  // even and odd banks: a pair of neighbours always sits one in each
  logic signed [SampleW-1:0] even_rom [EvenDepth];
  logic signed [SampleW-1:0] odd_rom  [OddDepth];

  for (genvar j = 0; j < EvenDepth; j++) begin : g_even
    assign even_rom[j] = elastic_sample(64'(2 * j));
  end

  for (genvar j = 0; j < OddDepth; j++) begin : g_odd
    assign odd_rom[j] = elastic_sample(64'(2 * j + 1));
  end

  logic [EvenW-1:0]          even_addr;
  logic [OddW-1:0]           odd_addr;
  logic signed [SampleW-1:0] even_q;
  logic signed [SampleW-1:0] odd_q;
  logic                      swap_q;

  assign even_addr = EvenW'(idx_i[IdxW-1:1]) + EvenW'(idx_i[0]);
  assign odd_addr  = idx_i[1 +: OddW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      even_q <= even_rom[even_addr];
      odd_q  <= odd_rom[odd_addr];
      swap_q <= idx_i[0];
    end
  end

  assign lo_o = swap_q ? odd_q : even_q;
  assign hi_o = swap_q ? even_q : odd_q;

endmodule

`default_nettype wire

// File: hdl/eas_curve.sv
`default_nettype none

module eas_curve import eas_pkg::*; #(
  parameter int unsigned FracBits   = 16,
  parameter int unsigned TableDepth = 256
) (
  input  wire logic                      clk_i,
  input  wire stage_en_t                 en_i,
  input  wire logic [ModeW-1:0]          mode_i,
  input  wire logic [FracBits:0]         progress_i,
  output logic signed [FracBits+1:0]     eased_o
);

  localparam int unsigned OpW   = FracBits + 2;
  localparam int unsigned SqW   = 2 * OpW;
  localparam int unsigned WideW = FracBits + 5;
  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned PW    = FracBits + 1 + IdxW;
  localparam int unsigned ProdW = SampleW + FracBits + 2;
  localparam int unsigned ValW  = SampleW + 2;
  localparam int unsigned Drop  = SampleFrac - FracBits;

  localparam logic [FracBits:0] One   = {1'b1, {FracBits{1'b0}}};
  localparam logic [FracBits:0] Half  = One >> 1;
  localparam logic [FracBits:0] Off3q = One - (One >> 2);
  localparam logic [FracBits:0] Off15 = One - (One >> 4);
  localparam logic [FracBits:0] Off63 = One - (One >> 6);

  localparam logic [WideW-1:0] K4  = WideW'(4) << FracBits;
  localparam logic [WideW-1:0] K6  = WideW'(6) << FracBits;
  localparam logic [WideW-1:0] K8  = WideW'(8) << FracBits;
  localparam logic [WideW-1:0] K9  = WideW'(9) << FracBits;
  localparam logic [WideW-1:0] K10 = WideW'(10) << FracBits;
  localparam logic [WideW-1:0] K21 = WideW'(21) << FracBits;

  localparam logic [SqW:0] RndHalf = (SqW + 1)'(1) << (FracBits - 2);
  localparam logic [SqW:0] RndOne  = (SqW + 1)'(1) << (FracBits - 1);
  localparam logic [SqW:0] RndB4   = (SqW + 1)'(1) << (FracBits + 3);
  localparam logic [SqW:0] RndB6   = (SqW + 1)'(1) << (FracBits + 5);

  localparam logic signed [ProdW-1:0] HalfP  = ProdW'(1) << (FracBits - 1);
  localparam logic signed [ValW-1:0]  HalfV  = ValW'(1) << (Drop - 1);
  localparam logic signed [ValW-1:0]  OneV   = ValW'(One);
  localparam logic signed [ValW-1:0]  NegOne = -ValW'(One);

  typedef enum logic [2:0] {
    KIND_LIN = 3'b001,
    KIND_SQR = 3'b010,
    KIND_ELA = 3'b100
  } kind_e;

  typedef enum logic [1:0] {
    SH_HALF = 2'd0,
    SH_ONE  = 2'd1,
    SH_B4   = 2'd2,
    SH_B6   = 2'd3
  } shift_e;

  typedef enum logic [1:0] {
    OFF_NONE = 2'd0,
    OFF_3Q   = 2'd1,
    OFF_15   = 2'd2,
    OFF_63   = 2'd3
  } off_e;

  // ---- prep: clamp t, pick the value to square, ROM index ----
  logic [FracBits:0] t;
  logic [FracBits:0] u;
  logic [WideW-1:0]  t11;
  logic [WideW-1:0]  t22;
  logic [WideW-1:0]  d6;
  logic [WideW-1:0]  d9;
  logic [WideW-1:0]  d21;
  logic [PW-1:0]     p;
  kind_e             kind;
  shift_e            sh;
  off_e              off;
  logic              inv;
  logic [OpW-1:0]    op;

  assign t   = (progress_i > One) ? One : progress_i;
  assign u   = One - t;
  assign t11 = (WideW'(t) << 3) + (WideW'(t) << 1) + WideW'(t);
  assign t22 = t11 << 1;
  assign d6  = (t11 >= K6) ? t11 - K6 : K6 - t11;
  assign d9  = (t11 >= K9) ? t11 - K9 : K9 - t11;
  assign d21 = (t22 >= K21) ? t22 - K21 : K21 - t22;
  assign p   = PW'(t) * PW'(TableDepth - 1);

  always_comb begin
    kind = KIND_LIN;
    sh   = SH_ONE;
    off  = OFF_NONE;
    inv  = 1'b0;
    op   = '0;
    unique case (mode_i)
      MODE_IN: begin
        kind = KIND_SQR;
        op   = OpW'(t);
      end
      MODE_OUT: begin
        kind = KIND_SQR;
        op   = OpW'(u);
        inv  = 1'b1;
      end
      MODE_IN_OUT: begin
        kind = KIND_SQR;
        sh   = SH_HALF;
        if (t < Half) begin
          op = OpW'(t);
        end else begin
          op  = OpW'(u);
          inv = 1'b1;
        end
      end
      MODE_BOUNCE: begin
        kind = KIND_SQR;
        sh   = SH_B4;
        if (t11 < K4) begin
          op = OpW'(t11);
        end else if (t11 < K8) begin
          op  = OpW'(d6);
          off = OFF_3Q;
        end else if (t11 < K10) begin
          op  = OpW'(d9);
          off = OFF_15;
        end else begin
          op  = OpW'(d21);
          sh  = SH_B6;
          off = OFF_63;
        end
      end
      MODE_ELASTIC: begin
        // the end points are exact, not read from the table
        if (t != '0 && t != One) begin
          kind = KIND_ELA;
        end
      end
      default: begin
        kind = KIND_LIN;
      end
    endcase
  end

  kind_e               kind_a_q;
  shift_e              sh_a_q;
  off_e                off_a_q;
  logic                inv_a_q;
  logic [OpW-1:0]      op_a_q;
  logic [FracBits:0]   t_a_q;
  logic [IdxW-1:0]     idx_a_q;
  logic [FracBits-1:0] fr_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StPrep]) begin
      kind_a_q <= kind;
      sh_a_q   <= sh;
      off_a_q  <= off;
      inv_a_q  <= inv;
      op_a_q   <= op;
      t_a_q    <= t;
      idx_a_q  <= p[FracBits +: IdxW];
      fr_a_q   <= p[FracBits-1:0];
    end
  end

  // ---- square and table read ----
  kind_e               kind_b_q;
  shift_e              sh_b_q;
  off_e                off_b_q;
  logic                inv_b_q;
  logic [SqW-1:0]      sq_b_q;
  logic [FracBits:0]   t_b_q;
  logic [FracBits-1:0] fr_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StSquare]) begin
      kind_b_q <= kind_a_q;
      sh_b_q   <= sh_a_q;
      off_b_q  <= off_a_q;
      inv_b_q  <= inv_a_q;
      sq_b_q   <= op_a_q * op_a_q;
      t_b_q    <= t_a_q;
      fr_b_q   <= fr_a_q;
    end
  end

  logic signed [SampleW-1:0] lo;
  logic signed [SampleW-1:0] hi;

  eas_rom #(
    .TableDepth (TableDepth)
  ) u_rom (
    .clk_i (clk_i),
    .en_i  (en_i[StSquare]),
    .idx_i (idx_a_q),
    .lo_o  (lo),
    .hi_o  (hi)
  );

  // ---- round the square, weight the table step ----
  logic [SqW:0]               sq_x;
  logic [SqW:0]               rnd_sel;
  logic [FracBits:0]          rnd;
  logic [FracBits:0]          off_val;
  logic [FracBits:0]          eq;
  logic signed [SampleW:0]    step;
  logic signed [FracBits:0]   frs;
  logic signed [ProdW-1:0]    prod;

  assign sq_x = {1'b0, sq_b_q};

  always_comb begin
    case (sh_b_q)
      SH_HALF: rnd_sel = (sq_x + RndHalf) >> (FracBits - 1);
      SH_ONE:  rnd_sel = (sq_x + RndOne) >> FracBits;
      SH_B4:   rnd_sel = (sq_x + RndB4) >> (FracBits + 4);
      SH_B6:   rnd_sel = (sq_x + RndB6) >> (FracBits + 6);
      default: rnd_sel = '0;
    endcase
    case (off_b_q)
      OFF_3Q:  off_val = Off3q;
      OFF_15:  off_val = Off15;
      OFF_63:  off_val = Off63;
      default: off_val = '0;
    endcase
  end

  assign rnd  = rnd_sel[FracBits:0];
  assign eq   = inv_b_q ? One - rnd : rnd + off_val;
  assign step = $signed({hi[SampleW-1], hi}) - $signed({lo[SampleW-1], lo});
  assign frs  = $signed({1'b0, fr_b_q});
  assign prod = step * frs;

  kind_e                     kind_c_q;
  logic [FracBits:0]         t_c_q;
  logic [FracBits:0]         eq_c_q;
  logic signed [SampleW-1:0] lo_c_q;
  logic signed [ProdW-1:0]   prod_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StMix]) begin
      kind_c_q <= kind_b_q;
      t_c_q    <= t_b_q;
      eq_c_q   <= eq;
      lo_c_q   <= lo;
      prod_c_q <= prod;
    end
  end

  // ---- finish the elastic sample, pick the result ----
  logic signed [ProdW-1:0]    prod_r;
  logic signed [ProdW-1:0]    prod_s;
  logic signed [ValW-1:0]     val;
  logic signed [ValW-1:0]     e_r;
  logic signed [ValW-1:0]     e_s;
  logic signed [ValW-1:0]     e_cl;
  logic signed [FracBits+1:0] eased;

  assign prod_r = prod_c_q + HalfP;
  assign prod_s = prod_r >>> FracBits;
  assign val    = ValW'(prod_s) + $signed({{2{lo_c_q[SampleW-1]}}, lo_c_q});
  assign e_r    = val + HalfV;
  assign e_s    = e_r >>> Drop;

  always_comb begin
    if (e_s > OneV) begin
      e_cl = OneV;
    end else if (e_s < NegOne) begin
      e_cl = NegOne;
    end else begin
      e_cl = e_s;
    end
    case (kind_c_q)
      KIND_SQR: eased = $signed({1'b0, eq_c_q});
      KIND_ELA: eased = e_cl[FracBits+1:0];
      default:  eased = $signed({1'b0, t_c_q});
    endcase
  end

  logic signed [FracBits+1:0] eased_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StEase]) begin
      eased_d_q <= eased;
    end
  end

  assign eased_o = eased_d_q;

endmodule

`default_nettype wire

// File: hdl/eas_lerp.sv
`default_nettype none

module eas_lerp import eas_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  wire logic                       clk_i,
  input  wire stage_en_t                  en_i,
  input  wire coord_t                     start_i [NumCoords],
  input  wire coord_t                     end_i [NumCoords],
  input  wire logic signed [FracBits+1:0] eased_i,
  output logic signed [FracBits+1:0]      eased_o,
  output coord_t                          pos_o [NumCoords]
);

  localparam int unsigned DlyLen = StEase + 1;
  localparam int unsigned ScW    = CoordW + FracBits + 3;
  localparam int unsigned SumW   = CoordW + 3;

  localparam logic signed [ScW-1:0]  HalfS = ScW'(1) << (FracBits - 1);
  localparam logic signed [SumW-1:0] MaxV  = (SumW'(1) << (CoordW - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] MinV  = -(SumW'(1) << (CoordW - 1));
  localparam coord_t                 CMax  = {1'b0, {(CoordW - 1){1'b1}}};
  localparam coord_t                 CMin  = {1'b1, {(CoordW - 1){1'b0}}};

  // hold start and span alongside the curve stages
  coord_t                  st_q [DlyLen][NumCoords];
  logic signed [CoordW:0]  df_q [DlyLen][NumCoords];

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumCoords; c++) begin
      if (en_i[StPrep]) begin
        st_q[0][c] <= start_i[c];
        df_q[0][c] <= $signed({end_i[c][CoordW-1], end_i[c]})
                    - $signed({start_i[c][CoordW-1], start_i[c]});
      end
      for (int k = 1; k < DlyLen; k++) begin
        if (en_i[k]) begin
          st_q[k][c] <= st_q[k-1][c];
          df_q[k][c] <= df_q[k-1][c];
        end
      end
    end
  end

  // ---- scale the span ----
  logic signed [ScW-1:0]      sc_e_q [NumCoords];
  coord_t                     st_e_q [NumCoords];
  logic signed [FracBits+1:0] eased_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StScale]) begin
      for (int c = 0; c < NumCoords; c++) begin
        sc_e_q[c] <= df_q[DlyLen-1][c] * eased_i;
        st_e_q[c] <= st_q[DlyLen-1][c];
      end
      eased_e_q <= eased_i;
    end
  end

  // ---- round, add start, saturate ----
  logic signed [ScW-1:0]  sc_r [NumCoords];
  logic signed [ScW-1:0]  sc_s [NumCoords];
  logic signed [SumW-1:0] sum  [NumCoords];
  coord_t                 pos  [NumCoords];

  always_comb begin
    for (int c = 0; c < NumCoords; c++) begin
      sc_r[c] = sc_e_q[c] + HalfS;
      sc_s[c] = sc_r[c] >>> FracBits;
      sum[c]  = SumW'(sc_s[c]) + $signed({{3{st_e_q[c][CoordW-1]}}, st_e_q[c]});
      if (sum[c] > MaxV) begin
        pos[c] = CMax;
      end else if (sum[c] < MinV) begin
        pos[c] = CMin;
      end else begin
        pos[c] = sum[c][CoordW-1:0];
      end
    end
  end

  coord_t                     pos_f_q [NumCoords];
  logic signed [FracBits+1:0] eased_f_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StOut]) begin
      for (int c = 0; c < NumCoords; c++) begin
        pos_f_q[c] <= pos[c];
      end
      eased_f_q <= eased_e_q;
    end
  end

  assign pos_o   = pos_f_q;
  assign eased_o = eased_f_q;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import eas_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned ProgW      = FracBits + 1;
  localparam int unsigned EasedW     = FracBits + 2;
  localparam int unsigned InFieldW   = ModeW + ProgW + 2 * NumCoords * CoordW;
  localparam int unsigned InW        = ((InFieldW + 7) / 8) * 8;
  localparam int unsigned OutFieldW  = EasedW + NumCoords * CoordW;
  localparam int unsigned OutW       = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned NumRandom  = 1000;

  localparam longint One           = longint'(1) << FracBits;
  localparam longint unsigned Q30  = 64'd1 << 30;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;
  localparam longint unsigned Ln2Q30   = 64'd744261118;
  localparam longint CoordMax      = 64'sd2147483647;
  localparam longint CoordMin      = -64'sd2147483648;

  // modes without a curve of their own, treated as linear
  localparam logic [ModeW-1:0] MODE_RESERVED_A = 3'd6;
  localparam logic [ModeW-1:0] MODE_RESERVED_B = 3'd7;

  typedef logic [NumCoords-1:0][CoordW-1:0] triple_t;

  // packed from the top down: mode ends up in the lowest bits, as on tdata
  typedef struct packed {
    triple_t               dest;
    triple_t               start;
    logic [ProgW-1:0]      progress;
    logic [ModeW-1:0]      mode;
  } motion_t;

  typedef struct packed {
    triple_t               pos;
    logic [EasedW-1:0]     eased;
  } point_t;

  typedef enum logic [1:0] {
    BY_MODEL,
    AT_START,
    AT_END
  } row_check_e;

  typedef struct packed {
    motion_t    req;
    row_check_e check;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic [InW-1:0] s_data = '0;
  logic m_ready = 1'b0;
  logic steady = 1'b0;
  logic s_ready;
  logic m_valid;
  logic [OutW-1:0] m_data;

  int elastic_samples [TableDepth];
  point_t pending_points [$];
  int mismatches = 0;
  int checked = 0;
  int sent_directed = 0;
  int sent_random = 0;
  logic [7:0] modes_seen = '0;

  always #5 clk = ~clk;

  easing_interpolator #(
    .FracBits  (FracBits),
    .TableDepth(TableDepth)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  // round to nearest, ties towards plus infinity
  function automatic longint round_shift(longint v, int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // elastic samples: -(2^(10(x-1)) * sin(2pi(x-1.075)/0.3)) in Q2.30
  initial begin : build_elastic
    longint unsigned idx, d1, m, ph, quad, r, q, x, x2, term, k, fr, y, mag;
    longint sn;
    d1 = TableDepth - 1;
    m = 12 * d1;
    for (idx = 0; idx < TableDepth; idx++) begin
      ph = (((40 * idx + 5 * d1) % m) << 32) / m;
      quad = (ph >> 30) & 64'd3;
      r = ph & (Q30 - 1);
      q = quad[0] ? Q30 - r : r;
      x = (q * TwoPiQ30) >> 32;
      x2 = (x * x) >> 30;
      term = Q30;
      // Horner over the odd terms, divisors (2n)(2n+1) from x^11 down
      for (longint unsigned n = 5; n >= 1; n--)
        term = Q30 - ((x2 * term) >> 30) / (2 * n * (2 * n + 1));
      term = (x * term) >> 30;
      sn = quad[1] ? -longint'(term) : longint'(term);
      k = (10 * idx) / d1;
      fr = (((10 * idx) % d1) << 30) / d1;
      y = (fr * Ln2Q30) >> 30;
      mag = Q30;
      for (longint unsigned n = 10; n >= 1; n--)
        mag = Q30 + ((y * mag) >> 30) / n;
      mag = mag >> (10 - k);
      elastic_samples[idx] = int'(-round_shift(longint'(mag) * sn, 30));
    end
  end

  function automatic point_t predict_point(motion_t req);
    point_t res;
    longint t, u, e, v, w, p, a, b, val, s, d, pos;
    t = longint'(req.progress);
    if (t > One) t = One;
    u = One - t;
    case (req.mode)
      MODE_IN: e = round_shift(t * t, FracBits);
      MODE_OUT: e = One - round_shift(u * u, FracBits);
      MODE_IN_OUT: begin
        if (t < One / 2) e = round_shift(t * t, FracBits - 1);
        else e = One - round_shift(u * u, FracBits - 1);
      end
      MODE_BOUNCE: begin
        v = 11 * t;
        if (v < 4 * One) begin
          e = round_shift(v * v, FracBits + 4);
        end else if (v < 8 * One) begin
          w = v - 6 * One;
          e = round_shift(w * w, FracBits + 4) + 3 * One / 4;
        end else if (v < 10 * One) begin
          w = v - 9 * One;
          e = round_shift(w * w, FracBits + 4) + 15 * One / 16;
        end else begin
          w = 22 * t - 21 * One;
          e = round_shift(w * w, FracBits + 6) + 63 * One / 64;
        end
      end
      MODE_ELASTIC: begin
        if (t == 0 || t == One) begin
          e = t;
        end else begin
          p = t * (TableDepth - 1);
          a = longint'(elastic_samples[p >>> FracBits]);
          b = longint'(elastic_samples[(p >>> FracBits) + 1]);
          val = a + round_shift((b - a) * (p & (One - 1)), FracBits);
          e = round_shift(val, SampleFrac - FracBits);
          if (e > One) e = One;
          if (e < -One) e = -One;
        end
      end
      default: e = t;
    endcase
    res.eased = e[EasedW-1:0];
    for (int c = 0; c < NumCoords; c++) begin
      s = longint'($signed(req.start[c]));
      d = longint'($signed(req.dest[c])) - s;
      pos = s + round_shift(d * e, FracBits);
      if (pos > CoordMax) pos = CoordMax;
      if (pos < CoordMin) pos = CoordMin;
      res.pos[c] = pos[CoordW-1:0];
    end
    return res;
  endfunction

  function automatic row_t mk(logic [ModeW-1:0] mode, longint prog, triple_t start,
                              triple_t dest, row_check_e check);
    row_t row;
    row.req.mode = mode;
    row.req.progress = prog[ProgW-1:0];
    row.req.start = start;
    row.req.dest = dest;
    row.check = check;
    return row;
  endfunction

  function automatic logic [CoordW-1:0] random_coord();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return CoordW'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    if (pick < 8) return $urandom;
    if (pick == 8) return 32'h7FFF_FFFF;
    return 32'h8000_0000;
  endfunction

  task automatic send(motion_t req, point_t want);
    if (!steady)
      while ($urandom_range(0, 99) < 14) begin
        s_valid <= 1'b0;
        @(posedge clk);
      end
    s_valid <= 1'b1;
    s_data <= InW'(req);
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    pending_points.insert(pending_points.size(), want);
    modes_seen[req.mode] = 1'b1;
  endtask

  task automatic flag(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t result %0d %s: expected %0d, got %0d", $realtime, checked, what,
               want, got);
  endtask

  always @(posedge clk) begin
    if (!steady && $urandom_range(0, 99) < 14) m_ready <= 1'b0;
    else m_ready <= 1'b1;
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && m_valid && m_ready) begin
      got = point_t'(m_data[OutFieldW-1:0]);
      if (pending_points.size() == 0) begin
        flag("unexpected transfer, eased", 0, longint'($signed(got.eased)));
      end else begin
        want = pending_points.pop_front();
        if (got.eased !== want.eased)
          flag("eased", longint'($signed(want.eased)), longint'($signed(got.eased)));
        for (int c = 0; c < NumCoords; c++)
          if (got.pos[c] !== want.pos[c])
            flag($sformatf("pos[%0d]", c), longint'($signed(want.pos[c])),
                 longint'($signed(got.pos[c])));
      end
      checked++;
    end
  end

  initial begin
    row_t plan [$];
    triple_t p0, d0, lo, hi, near_lo, near_hi;
    motion_t req;
    point_t want;
    int unsigned pick;

    p0 = {32'h0001_8000, 32'hFFFE_8000, 32'h0000_0000};
    d0 = {32'h0004_0000, 32'h0000_4000, 32'hFFF0_0000};
    lo = {NumCoords{32'h8000_0000}};
    hi = {NumCoords{32'h7FFF_FFFF}};
    near_lo = {NumCoords{32'h8000_1000}};
    near_hi = {NumCoords{32'h7FFF_F000}};

    // start and dest are written {z, y, x}
    plan.insert(plan.size(), mk(MODE_LINEAR,     0,           p0,      d0, AT_START));
    plan.insert(plan.size(), mk(MODE_LINEAR,     One,         p0,      d0, AT_END));
    plan.insert(plan.size(), mk(MODE_LINEAR,     'h1FFFF,     lo,      hi, AT_END));
    plan.insert(plan.size(), mk(MODE_LINEAR,     One + 1,     hi,      lo, AT_END));
    plan.insert(plan.size(), mk(MODE_LINEAR,     One / 2,     lo,      hi, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_IN,         0,           d0,      p0, AT_START));
    plan.insert(plan.size(), mk(MODE_IN,         One,         d0,      p0, AT_END));
    plan.insert(plan.size(), mk(MODE_IN,         12345,       p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_OUT,        0,           p0,      d0, AT_START));
    plan.insert(plan.size(), mk(MODE_OUT,        One,         p0,      d0, AT_END));
    plan.insert(plan.size(), mk(MODE_OUT,        40000,       p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_IN_OUT,     One / 2 - 1, p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_IN_OUT,     One / 2,     p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_IN_OUT,     One,         lo,      hi, AT_END));
    plan.insert(plan.size(), mk(MODE_BOUNCE,     0,           p0,      d0, AT_START));
    plan.insert(plan.size(), mk(MODE_BOUNCE,     23832,       p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_BOUNCE,     47663,       p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_BOUNCE,     59579,       p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_BOUNCE,     One,         p0,      d0, AT_END));
    plan.insert(plan.size(), mk(MODE_ELASTIC,    0,           p0,      d0, AT_START));
    plan.insert(plan.size(), mk(MODE_ELASTIC,    One,         p0,      d0, AT_END));
    plan.insert(plan.size(), mk(MODE_ELASTIC,    1,           p0,      d0, BY_MODEL));
    // the curve dips well below zero here: overshoot past both rails
    plan.insert(plan.size(), mk(MODE_ELASTIC,    55706,       near_lo, hi, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_ELASTIC,    55706,       near_hi, lo, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_RESERVED_A, One / 3,     p0,      d0, BY_MODEL));
    plan.insert(plan.size(), mk(MODE_RESERVED_B, One,         p0,      d0, AT_END));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      req = plan[i].req;
      case (plan[i].check)
        AT_START: want = '{pos: req.start, eased: '0};
        AT_END:   want = '{pos: req.dest, eased: EasedW'(One)};
        default:  want = predict_point(req);
      endcase
      send(req, want);
      sent_directed++;
    end

    for (int n = 0; n < NumRandom; n++) begin
      steady <= (n >= 400 && n < 600);
      req.mode = ModeW'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        req.progress = ProgW'($urandom_range(0, One));
      end else if (pick < 82) begin
        req.progress = ProgW'($urandom_range(0, 2 * One - 1));
      end else if (pick < 92) begin
        case ($urandom_range(0, 5))
          0: req.progress = '0;
          1: req.progress = ProgW'(One);
          2: req.progress = ProgW'(One / 2);
          3: req.progress = ProgW'(23831 + $urandom_range(0, 1));
          4: req.progress = ProgW'(47662 + $urandom_range(0, 1));
          default: req.progress = ProgW'(59578 + $urandom_range(0, 1));
        endcase
      end else begin
        req.progress = ProgW'($urandom_range(0, 1) ? $urandom_range(0, 255)
                                                   : One - $urandom_range(0, 255));
      end
      for (int c = 0; c < NumCoords; c++) begin
        req.start[c] = random_coord();
        req.dest[c] = random_coord();
      end
      send(req, predict_point(req));
      sent_random++;
    end
    s_valid <= 1'b0;
    steady <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    // let any stray transfer surface before judging
    repeat (12) @(posedge clk);

    $display("Covered %0d input transfers (%0d directed, %0d random), modes seen %b;",
             sent_directed + sent_random, sent_directed, sent_random, modes_seen);
    $display("%0d results compared field by field, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Timed out with %0d results outstanding.", pending_points.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hdl/eas_pkg.sv
hdl/eas_rom.sv
hdl/eas_curve.sv
hdl/eas_lerp.sv
hdl/easing_interpolator.sv
bench/tb_top.sv
